/* design/tace_pkg.sv */
// Shared types, constants and field helpers for the three-address execute block.
// No dependencies; imported by every module of the block.
package tace_pkg;

    localparam int DATA_WORDS = 256;
    localparam int ADDR_W     = $clog2(DATA_WORDS);
    localparam int WORD_W     = 16;
    localparam int REG_COUNT  = 8;
    localparam int RIDX_W     = $clog2(REG_COUNT);
    localparam int INSN_W     = 32;

    localparam logic OPER_EXEC = 1'b0;
    localparam logic OPER_LOAD = 1'b1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [RIDX_W-1:0] ridx_t;
    typedef logic [ADDR_W-1:0] maddr_t;

    typedef enum logic [3:0] {
        OP_LTR  = 4'd0,
        OP_RTM  = 4'd1,
        OP_ADDL = 4'd2,
        OP_MTR  = 4'd3,
        OP_JIL  = 4'd4,
        OP_RTR  = 4'd5,
        OP_ADD  = 4'd6,
        OP_MUL  = 4'd7,
        OP_END  = 4'd8
    } opcode_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] instruction;
        logic [7:0]  load_addr;
        logic [15:0] load_value;
        logic [2:0]  probe_index;
    } cmd_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        halted;
        logic [15:0] probe_value;
    } rsp_t;

    typedef struct packed {
        logic  we;
        ridx_t idx;
        word_t data;
    } rf_wr_t;

    typedef struct packed {
        logic   we;
        logic   re;
        maddr_t addr;
        word_t  data;
    } mem_req_t;

    typedef struct packed {
        rf_wr_t   wr_dest;
        rf_wr_t   wr_op1;
        logic     load_dest;
        mem_req_t mem;
        word_t    next_pc;
        logic     halted;
    } exec_t;

    function automatic opcode_t insn_opcode(input logic [INSN_W-1:0] insn);
        return opcode_t'(insn[31:28]);
    endfunction

    function automatic word_t insn_literal(input logic [INSN_W-1:0] insn);
        return insn[24:9];
    endfunction

    function automatic ridx_t insn_dest(input logic [INSN_W-1:0] insn);
        return insn[8:6];
    endfunction

    function automatic ridx_t insn_op1(input logic [INSN_W-1:0] insn);
        return insn[5:3];
    endfunction

    function automatic ridx_t insn_op2(input logic [INSN_W-1:0] insn);
        return insn[2:0];
    endfunction

endpackage

/* design/tace_regfile.sv */
// Eight-entry register file in flops, three write ports, four read ports.
// Depends on tace_pkg.
module tace_regfile (
    input  logic            clk,
    input  logic            rst_n,
    input  tace_pkg::rf_wr_t wr_load,
    input  tace_pkg::rf_wr_t wr_dest,
    input  tace_pkg::rf_wr_t wr_op1,
    input  tace_pkg::ridx_t idx_a,
    input  tace_pkg::ridx_t idx_b,
    input  tace_pkg::ridx_t idx_d,
    input  tace_pkg::ridx_t idx_p,
    output tace_pkg::word_t val_a,
    output tace_pkg::word_t val_b,
    output tace_pkg::word_t val_d,
    output tace_pkg::word_t val_p
);
    import tace_pkg::*;

    word_t rf_reg  [REG_COUNT];
    word_t rf_next [REG_COUNT];

    // later ports win: memory load is the oldest item, op1 write last
    always_comb
    begin
        for (int i = 0; i < REG_COUNT; i++)
        begin
            rf_next[i] = rf_reg[i];
            if (wr_load.we && wr_load.idx == ridx_t'(i))
            begin
                rf_next[i] = wr_load.data;
            end
            if (wr_dest.we && wr_dest.idx == ridx_t'(i))
            begin
                rf_next[i] = wr_dest.data;
            end
            if (wr_op1.we && wr_op1.idx == ridx_t'(i))
            begin
                rf_next[i] = wr_op1.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= rf_next[i];
            end
        end
    end

    assign val_a = rf_reg[idx_a];
    assign val_b = rf_reg[idx_b];
    assign val_d = rf_reg[idx_d];
    assign val_p = rf_reg[idx_p];

endmodule

/* design/tace_dmem.sv */
// Data memory with registered read and per-word valid bits (unwritten reads zero).
// Depends on tace_pkg.
module tace_dmem (
    input  logic              clk,
    input  logic              rst_n,
    input  tace_pkg::mem_req_t req,
    output tace_pkg::word_t   rdata
);
    import tace_pkg::*;

    word_t                 mem_array [DATA_WORDS];
    logic [DATA_WORDS-1:0] valid_reg;
    word_t                 rdata_reg;
    logic                  rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.addr] <= req.data;
        end
        if (req.re)
        begin
            rdata_reg <= mem_array[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.re)
            begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

/* design/tace_exec.sv */
// Instruction decode and execute: register writes, memory request, next pc.
// Depends on tace_pkg.
module tace_exec (
    input  tace_pkg::cmd_t  cmd,
    input  tace_pkg::word_t pc,
    input  tace_pkg::word_t op1_val,
    input  tace_pkg::word_t op2_val,
    input  tace_pkg::word_t dest_val,
    output tace_pkg::exec_t ex
);
    import tace_pkg::*;

    opcode_t              opc;
    word_t                lit;
    logic [2*WORD_W-1:0]  prod;

    assign opc  = insn_opcode(cmd.instruction);
    assign lit  = insn_literal(cmd.instruction);
    assign prod = op1_val * op2_val;

    always_comb
    begin
        ex              = '0;
        ex.wr_dest.idx  = insn_dest(cmd.instruction);
        ex.wr_op1.idx   = insn_op1(cmd.instruction);
        ex.next_pc      = word_t'(pc + word_t'(1));
        if (cmd.operation == OPER_LOAD)
        begin
            ex.mem.we   = 1'b1;
            ex.mem.addr = maddr_t'(cmd.load_addr);
            ex.mem.data = cmd.load_value;
            ex.next_pc  = pc;
        end
        else
        begin
            unique case (opc)
                OP_LTR:
                begin
                    ex.wr_dest.we   = 1'b1;
                    ex.wr_dest.data = lit;
                end
                OP_RTM:
                begin
                    ex.mem.we   = 1'b1;
                    ex.mem.addr = maddr_t'(dest_val);
                    ex.mem.data = op1_val;
                end
                OP_ADDL:
                begin
                    ex.wr_dest.we   = 1'b1;
                    ex.wr_dest.data = word_t'(op1_val + lit);
                end
                OP_MTR:
                begin
                    ex.mem.re    = 1'b1;
                    ex.mem.addr  = maddr_t'(op1_val);
                    ex.load_dest = 1'b1;
                end
                OP_JIL:
                begin
                    if (op1_val < op2_val)
                    begin
                        ex.next_pc = lit;
                    end
                end
                OP_RTR:
                begin
                    ex.wr_dest.we   = 1'b1;
                    ex.wr_dest.data = op1_val;
                end
                OP_ADD:
                begin
                    ex.wr_dest.we   = 1'b1;
                    ex.wr_dest.data = word_t'(op1_val + op2_val);
                end
                OP_MUL:
                begin
                    ex.wr_dest.we   = 1'b1;
                    ex.wr_dest.data = prod[WORD_W-1:0];
                    ex.wr_op1.we    = 1'b1;
                    ex.wr_op1.data  = prod[2*WORD_W-1:WORD_W];
                end
                OP_END:
                begin
                    ex.halted  = 1'b1;
                    ex.next_pc = pc;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* design/three_address_cpu_execute.sv */
// Three-address execute core: execute stage, memory-return stage, result register.
// An accepted item passes through the execute stage and the memory-return stage into the result register.
// Throughput: one item per cycle; the whole pipe holds only while the result is stalled.
// Memory loads return in the second stage and are forwarded to the next item.
// Reset clears registers, pc and the data memory valid bits; no clearing pass needed.
// Depends on tace_pkg, tace_exec, tace_regfile, tace_dmem.
module three_address_cpu_execute (
    input  logic           clk,
    input  logic           rst_n,
    input  tace_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    output tace_pkg::rsp_t rsp,
    output logic           rsp_valid,
    input  logic           rsp_stall
);
    import tace_pkg::*;

    logic     advance;
    logic     e_fire;

    logic     e_valid_reg;
    cmd_t     e_cmd_reg;
    word_t    pc_reg;

    logic     w_valid_reg;
    logic     w_load_reg;
    ridx_t    w_dest_reg;
    ridx_t    w_probe_reg;
    word_t    w_pc_reg;
    logic     w_halted_reg;

    logic     rsp_valid_reg;
    rsp_t     rsp_reg;

    ridx_t    idx_a;
    ridx_t    idx_b;
    ridx_t    idx_d;
    word_t    rf_a;
    word_t    rf_b;
    word_t    rf_d;
    word_t    rf_p;
    word_t    op1_val;
    word_t    op2_val;
    word_t    dest_val;
    word_t    probe_val;
    word_t    mem_rdata;
    logic     fwd_on;

    exec_t    ex;
    rf_wr_t   wr_load;
    rf_wr_t   wr_dest;
    rf_wr_t   wr_op1;
    mem_req_t mem_req;

    assign advance   = !(rsp_valid_reg && rsp_stall);
    assign cmd_stall = !advance;
    assign e_fire    = e_valid_reg && advance;

    assign idx_a = insn_op1(e_cmd_reg.instruction);
    assign idx_b = insn_op2(e_cmd_reg.instruction);
    assign idx_d = insn_dest(e_cmd_reg.instruction);

    // load result still in flight from the second stage
    assign fwd_on    = w_valid_reg && w_load_reg;
    assign op1_val   = (fwd_on && w_dest_reg == idx_a) ? mem_rdata : rf_a;
    assign op2_val   = (fwd_on && w_dest_reg == idx_b) ? mem_rdata : rf_b;
    assign dest_val  = (fwd_on && w_dest_reg == idx_d) ? mem_rdata : rf_d;
    assign probe_val = (fwd_on && w_dest_reg == w_probe_reg) ? mem_rdata : rf_p;

    tace_exec u_exec (
        .cmd      (e_cmd_reg),
        .pc       (pc_reg),
        .op1_val  (op1_val),
        .op2_val  (op2_val),
        .dest_val (dest_val),
        .ex       (ex)
    );

    always_comb
    begin
        wr_dest    = ex.wr_dest;
        wr_dest.we = ex.wr_dest.we && e_fire;
        wr_op1     = ex.wr_op1;
        wr_op1.we  = ex.wr_op1.we && e_fire;
        mem_req    = ex.mem;
        mem_req.we = ex.mem.we && e_fire;
        mem_req.re = ex.mem.re && e_fire;
        wr_load.we   = fwd_on && advance;
        wr_load.idx  = w_dest_reg;
        wr_load.data = mem_rdata;
    end

    tace_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_load (wr_load),
        .wr_dest (wr_dest),
        .wr_op1  (wr_op1),
        .idx_a   (idx_a),
        .idx_b   (idx_b),
        .idx_d   (idx_d),
        .idx_p   (w_probe_reg),
        .val_a   (rf_a),
        .val_b   (rf_b),
        .val_d   (rf_d),
        .val_p   (rf_p)
    );

    tace_dmem u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
            w_load_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end
        else if (advance)
        begin
            e_valid_reg   <= cmd_valid;
            w_valid_reg   <= e_valid_reg;
            w_load_reg    <= e_valid_reg && ex.load_dest;
            rsp_valid_reg <= w_valid_reg;
            if (e_valid_reg)
            begin
                pc_reg <= ex.next_pc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e_cmd_reg           <= cmd;
            w_dest_reg          <= idx_d;
            w_probe_reg         <= e_cmd_reg.probe_index;
            w_pc_reg            <= ex.next_pc;
            w_halted_reg        <= ex.halted;
            rsp_reg.next_pc     <= w_pc_reg;
            rsp_reg.halted      <= w_halted_reg;
            rsp_reg.probe_value <= probe_val;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for three_address_cpu_execute: directed and random items,
// a cycle-free model of the core in the predictor, random idle bursts on both channels.
// Depends on tace_pkg and the RTL of the block.
module tb_top;

    import tace_pkg::*;

    localparam int          RANDOM_TOTAL  = 1550;
    localparam int          CALM_TAIL     = 150;
    localparam logic [3:0]  OP_UNUSED_LO  = 4'd9;
    localparam logic [3:0]  OP_UNUSED_HI  = 4'd15;
    localparam int          MAX_PRINTS    = 60;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    cmd_t  cmd       = '0;
    logic  cmd_valid = 1'b0;
    logic  cmd_stall;
    rsp_t  rsp;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;

    cmd_t  pending_cmds [$];
    rsp_t  expected_rsps [$];
    rsp_t  want_rsp;

    word_t regs [REG_COUNT]  = '{default: '0};
    word_t dmem [DATA_WORDS] = '{default: '0};
    word_t core_pc           = '0;

    int    cmd_total      = 0;
    int    cmds_issued    = 0;
    int    results_seen   = 0;
    int    errors         = 0;
    int    n_exec         = 0;
    int    n_loads        = 0;
    int    n_jumps        = 0;
    int    n_halts        = 0;
    int    n_wraps        = 0;
    bit    cmd_taken      = 1'b0;
    int    send_gap       = 0;
    int    send_odds      = 0;
    int    stall_left     = 0;
    int    stall_odds     = 0;
    logic  calm;

    assign calm = (cmds_issued + CALM_TAIL >= cmd_total);

    three_address_cpu_execute dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic log_failure(input string msg);
        if (errors < MAX_PRINTS)
        begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        errors++;
    endtask

    function automatic logic [31:0] encode(input logic [3:0] opc, input word_t lit,
                                           input ridx_t d, input ridx_t a, input ridx_t b);
        return {opc, 3'b000, lit, d, a, b};
    endfunction

    function automatic cmd_t exec_item(input logic [31:0] word, input ridx_t probe);
        cmd_t c;
        c             = '0;
        c.operation   = OPER_EXEC;
        c.instruction = word;
        c.probe_index = probe;
        return c;
    endfunction

    function automatic cmd_t load_item(input logic [7:0] addr, input word_t value,
                                       input ridx_t probe);
        cmd_t c;
        c             = '0;
        c.operation   = OPER_LOAD;
        c.instruction = $urandom();
        c.load_addr   = addr;
        c.load_value  = value;
        c.probe_index = probe;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t        c;
        logic [3:0]  opc;
        int unsigned pick;
        c.instruction = $urandom();
        c.load_addr   = 8'($urandom());
        c.load_value  = 16'($urandom());
        c.probe_index = 3'($urandom());
        pick          = $urandom_range(0, 99);
        c.operation   = (pick < 12) ? OPER_LOAD : OPER_EXEC;
        if (pick < 12)
        begin
            opc = c.instruction[31:28];
        end
        else if (pick < 18)
        begin
            opc = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        else if (pick < 22)
        begin
            opc = OP_END;
        end
        else
        begin
            opc = 4'($urandom_range(OP_LTR, OP_MUL));
        end
        c.instruction[31:28] = opc;
        return c;
    endfunction

    // one step of the core: updates the model state, returns the expected result
    function automatic rsp_t core_step(input cmd_t c);
        logic [3:0]  opc;
        word_t       lit;
        word_t       npc;
        ridx_t       d;
        ridx_t       a;
        ridx_t       b;
        logic [31:0] prod;
        rsp_t        r;
        opc      = c.instruction[31:28];
        lit      = c.instruction[24:9];
        d        = c.instruction[8:6];
        a        = c.instruction[5:3];
        b        = c.instruction[2:0];
        r.halted = 1'b0;
        if (c.operation == OPER_LOAD)
        begin
            dmem[c.load_addr % DATA_WORDS] = c.load_value;
            n_loads++;
        end
        else
        begin
            npc = core_pc + 16'd1;
            n_exec++;
            case (opc)
                OP_LTR:  regs[d] = lit;
                OP_RTM:  dmem[regs[d] % DATA_WORDS] = regs[a];
                OP_ADDL: regs[d] = regs[a] + lit;
                OP_MTR:  regs[d] = dmem[regs[a] % DATA_WORDS];
                OP_JIL:
                begin
                    if (regs[a] < regs[b])
                    begin
                        npc = lit;
                        n_jumps++;
                    end
                end
                OP_RTR:  regs[d] = regs[a];
                OP_ADD:  regs[d] = regs[a] + regs[b];
                OP_MUL:
                begin
                    prod    = 32'(regs[a]) * 32'(regs[b]);
                    regs[d] = prod[15:0];
                    regs[a] = prod[31:16];
                end
                OP_END:
                begin
                    r.halted = 1'b1;
                    npc      = core_pc;
                    n_halts++;
                end
                default: ;
            endcase
            if (core_pc == 16'hFFFF && npc == 16'h0000)
            begin
                n_wraps++;
            end
            core_pc = npc;
        end
        r.next_pc     = core_pc;
        r.probe_value = regs[c.probe_index];
        return r;
    endfunction

    // driver: new item or gap at the falling edge once the current item is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd_valid || cmd_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 15) < send_odds)
                begin
                    send_gap = $urandom_range(0, 8);
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd       <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 15) < stall_odds)
            begin
                stall_left = $urandom_range(0, 8);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_taken = cmd_valid && !cmd_stall;
            if (cmd_taken)
            begin
                expected_rsps.push_back(core_step(cmd));
                cmds_issued++;
                if (cmds_issued % 64 == 0)
                begin
                    send_odds  = $urandom_range(0, 3);
                    stall_odds = $urandom_range(0, 3);
                end
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    log_failure($sformatf("result with nothing expected: pc %h halted %b probe %h",
                                          rsp.next_pc, rsp.halted, rsp.probe_value));
                end
                else
                begin
                    want_rsp = expected_rsps.pop_front();
                    results_seen++;
                    if (rsp.next_pc !== want_rsp.next_pc)
                    begin
                        log_failure($sformatf("result %0d next_pc %h, expected %h",
                                              results_seen, rsp.next_pc, want_rsp.next_pc));
                    end
                    if (rsp.halted !== want_rsp.halted)
                    begin
                        log_failure($sformatf("result %0d halted %b, expected %b",
                                              results_seen, rsp.halted, want_rsp.halted));
                    end
                    if (rsp.probe_value !== want_rsp.probe_value)
                    begin
                        log_failure($sformatf("result %0d probe_value %h, expected %h",
                                              results_seen, rsp.probe_value,
                                              want_rsp.probe_value));
                    end
                end
            end
        end
    end

    initial
    begin
        // extremes, wraparound, MUL overlap, memory aliasing, jumps and halts
        pending_cmds.push_back(exec_item(encode(OP_LTR, 16'hFFFF, 3'd1, 3'd0, 3'd0), 3'd1));
        pending_cmds.push_back(exec_item(encode(OP_LTR, 16'h8001, 3'd2, 3'd0, 3'd0), 3'd2));
        pending_cmds.push_back(exec_item(encode(OP_ADDL, 16'hFFFF, 3'd3, 3'd1, 3'd0), 3'd3));
        pending_cmds.push_back(exec_item(encode(OP_ADD, 16'h0000, 3'd4, 3'd1, 3'd2), 3'd4));
        pending_cmds.push_back(exec_item(encode(OP_MUL, 16'h0000, 3'd5, 3'd1, 3'd1), 3'd5));
        pending_cmds.push_back(exec_item(encode(OP_LTR, 16'h1234, 3'd6, 3'd0, 3'd0), 3'd6));
        pending_cmds.push_back(exec_item(encode(OP_MUL, 16'h0000, 3'd6, 3'd6, 3'd2), 3'd6));
        pending_cmds.push_back(load_item(8'hFF, 16'hFFFF, 3'd0));
        pending_cmds.push_back(load_item(8'h00, 16'hA5A5, 3'd7));
        pending_cmds.push_back(exec_item(encode(OP_RTM, 16'h0000, 3'd1, 3'd2, 3'd0), 3'd1));
        pending_cmds.push_back(exec_item(encode(OP_MTR, 16'h0000, 3'd7, 3'd1, 3'd0), 3'd7));
        pending_cmds.push_back(exec_item(encode(OP_LTR, 16'h00FF, 3'd0, 3'd0, 3'd0), 3'd0));
        pending_cmds.push_back(exec_item(encode(OP_MTR, 16'h0000, 3'd7, 3'd0, 3'd0), 3'd7));
        pending_cmds.push_back(exec_item(encode(OP_RTR, 16'h0000, 3'd0, 3'd7, 3'd0), 3'd0));
        pending_cmds.push_back(exec_item(encode(OP_JIL, 16'hFFFF, 3'd0, 3'd4, 3'd3), 3'd4));
        pending_cmds.push_back(exec_item(encode(OP_UNUSED_LO, 16'hFFFF, 3'd7, 3'd7, 3'd7),
                                         3'd7));
        pending_cmds.push_back(exec_item(encode(OP_JIL, 16'h7777, 3'd0, 3'd3, 3'd4), 3'd3));
        pending_cmds.push_back(exec_item(encode(OP_END, 16'h0000, 3'd0, 3'd0, 3'd0), 3'd2));
        pending_cmds.push_back(exec_item(encode(OP_END, 16'hFFFF, 3'd7, 3'd7, 3'd7), 3'd5));
        pending_cmds.push_back(exec_item(encode(OP_UNUSED_HI, 16'hFFFF, 3'd7, 3'd7, 3'd7),
                                         3'd6));
        pending_cmds.push_back(exec_item(encode(OP_LTR, 16'h0000, 3'd3, 3'd0, 3'd0), 3'd3));
        pending_cmds.push_back(exec_item(encode(OP_JIL, 16'h1111, 3'd0, 3'd3, 3'd3), 3'd3));
        while (pending_cmds.size() < RANDOM_TOTAL)
        begin
            pending_cmds.push_back(random_cmd());
        end
        cmd_total = pending_cmds.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid)
        begin
            @(negedge clk);
        end
        while (expected_rsps.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (12) @(negedge clk);
        if (expected_rsps.size() != 0)
        begin
            log_failure($sformatf("%0d results never arrived", expected_rsps.size()));
        end

        $display("Run: %0d instructions, %0d preloads, %0d taken jumps, %0d halts",
                 n_exec, n_loads, n_jumps, n_halts);
        $display("     %0d pc wraps, %0d results checked, %0d mismatches",
                 n_wraps, results_seen, errors);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout after %0d items accepted, %0d results", cmds_issued, results_seen);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* three_address_cpu_execute.f */
design/tace_pkg.sv
design/tace_regfile.sv
design/tace_dmem.sv
design/tace_exec.sv
design/three_address_cpu_execute.sv
tb/tb_top.sv
